// ===== sv/rcc_pkg.sv =====
// ============================================================================
// rcc_pkg
// Shared types, codes and CRC helper for the region CRC-16 check unit.
// ============================================================================
package rcc_pkg;

    // CRC-16 (0x1021, MSB first, initial value zero)
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] ERASED_MARK = 16'hFFFF;

    // Register map: index = paddr[3:2]
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_EXPECTED_CRC = 2'd0,
        REG_AUGMENT_MODE = 2'd1,
        REG_ERASED_SKIP  = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        STATUS_PASS     = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_SKIPPED  = 2'd2
    } check_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        check_status_t check_status;
        logic [15:0]   crc_value;
    } out_item_t;

    // Configuration handed from the register block to the datapath
    typedef struct packed {
        logic [15:0] expected_crc;
        logic        augment_mode;
        logic        erased_skip;
    } cfg_t;

    // Shift one byte, MSB first, into the CRC register
    function automatic logic [15:0] crc_shift_byte(input logic [15:0] crc,
                                                   input logic [7:0]  data);
        logic [15:0] c;
        logic [15:0] nxt;
        c = crc;
        for (int b = 0; b < 8; b++)
        begin
            nxt = {c[14:0], data[7 - b]};
            if (c[15])
            begin
                nxt = nxt ^ CRC_POLY;
            end
            c = nxt;
        end
        return c;
    endfunction

endpackage

// ===== sv/rcc_cfg_regs.sv =====
// ============================================================================
// rcc_cfg_regs
// APB-style configuration registers: expected CRC, augment mode, erased skip.
// ============================================================================
module rcc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcc_pkg::PADDR_W-1:0]   paddr,
    input  logic [rcc_pkg::PDATA_W-1:0]   pwdata,
    output logic [rcc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output rcc_pkg::cfg_t                 cfg
);
    import rcc_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    // Register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_crc <= 16'h0000;
            cfg_reg.augment_mode <= 1'b1;
            cfg_reg.erased_skip  <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_EXPECTED_CRC: cfg_reg.expected_crc <= pwdata[15:0];
                REG_AUGMENT_MODE: cfg_reg.augment_mode <= pwdata[0];
                REG_ERASED_SKIP:  cfg_reg.erased_skip  <= pwdata[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_EXPECTED_CRC: prdata[15:0] = cfg_reg.expected_crc;
            REG_AUGMENT_MODE: prdata[0]    = cfg_reg.augment_mode;
            REG_ERASED_SKIP:  prdata[0]    = cfg_reg.erased_skip;
            default:          prdata       = '0;
        endcase
    end

endmodule

// ===== sv/rcc_crc_core.sv =====
// ============================================================================
// rcc_crc_core
// Input register, running CRC register, finish/compare logic, result register.
// ============================================================================
module rcc_crc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  rcc_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  rcc_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output rcc_pkg::out_item_t  out_item
);
    import rcc_pkg::*;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    in_item_t      s1_item_reg;
    logic [15:0]   crc_reg;
    logic [15:0]   crc_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    out_item_t     out_item_reg;
    logic          s1_adv;
    logic          in_take;
    logic          fin;
    logic [15:0]   crc_byte;
    logic [15:0]   crc_aug;
    logic [15:0]   crc_final;
    check_status_t status;

    // Handshake: non-last bytes never need the result slot
    assign s1_adv    = s1_valid_reg &
                       (~s1_item_reg.last_byte | ~out_valid_reg | out_ready);
    assign fin       = s1_adv & s1_item_reg.last_byte;
    assign in_ready  = ~s1_valid_reg | s1_adv;
    assign in_take   = in_valid & in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // CRC update and optional two-zero-byte augmentation
    assign crc_byte  = crc_shift_byte(crc_reg, s1_item_reg.data_byte);
    assign crc_aug   = crc_shift_byte(crc_shift_byte(crc_byte, 8'h00), 8'h00);
    assign crc_final = cfg.augment_mode ? crc_aug : crc_byte;

    // Compare against the stored checksum
    always_comb
    begin
        priority if (cfg.erased_skip && (cfg.expected_crc == ERASED_MARK))
        begin
            status = STATUS_SKIPPED;
        end
        else if (crc_final != cfg.expected_crc)
        begin
            status = STATUS_MISMATCH;
        end
        else
        begin
            status = STATUS_PASS;
        end
    end

    // Next values of control and CRC state
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        crc_next = crc_reg;
        if (s1_adv)
        begin
            crc_next = s1_item_reg.last_byte ? 16'h0000 : crc_byte;
        end

        out_valid_next = out_valid_reg;
        if (fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and CRC registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            crc_reg       <= 16'h0000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_item;
        end
        if (fin)
        begin
            out_item_reg.check_status <= status;
            out_item_reg.crc_value    <= crc_final;
        end
    end

endmodule

// ===== sv/region_crc16_check_unit.sv =====
// A byte is registered in the input register on acceptance; a last byte's
// result is then registered in the result register, which raises out_valid.
// Throughput: one byte per cycle, set by the combinational byte CRC update.
// A waiting result holds a last byte in the input register and stalls input;
// other bytes keep flowing. Reset (rst_n, async, active low): CRC cleared,
// pipeline empty, expected_crc = 0, augment_mode = 1, erased_skip = 0.
// ============================================================================
// region_crc16_check_unit
// Streams region bytes through a CRC-16 and reports pass, mismatch or
// skipped against a programmable expected checksum.
// ============================================================================
module region_crc16_check_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcc_pkg::PADDR_W-1:0]   paddr,
    input  logic [rcc_pkg::PDATA_W-1:0]   pwdata,
    output logic [rcc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rcc_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rcc_pkg::out_item_t            out_item
);
    import rcc_pkg::*;

    cfg_t cfg;

    rcc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcc_crc_core u_crc_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

`ifndef ASSERT_OFF
    // A pass result carries exactly the expected checksum
    a_pass_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.check_status == STATUS_PASS))
        |-> (out_item.crc_value == cfg.expected_crc))
        else $error("pass reported with CRC differing from expected");

    // A mismatch result never carries the expected checksum
    a_mismatch_differs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.check_status == STATUS_MISMATCH))
        |-> (out_item.crc_value != cfg.expected_crc))
        else $error("mismatch reported with CRC equal to expected");

    // Erased store with skip enabled always reports skipped
    a_erased_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cfg.erased_skip && (cfg.expected_crc == ERASED_MARK))
        |-> (out_item.check_status == STATUS_SKIPPED))
        else $error("erased store not reported as skipped");
`endif

endmodule

// ===== verif/region_crc16_check_unit_test.sv =====
// ============================================================================
// region_crc16_check_unit_test
// Self-checking testbench for the region CRC-16 check unit. Byte streams are
// pushed through the valid/ready input with random bursts and gaps, results
// are drained under a shifting stall pattern, and every report is compared
// field by field with a CRC predictor that tracks the running region CRC and
// the register settings written over APB between test phases.
// ============================================================================
module region_crc16_check_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rcc_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // Index 3 has no register behind it; writes there must be dropped
    localparam logic [1:0]  REG_UNUSED_IDX = 2'd3;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned RANDOM_BYTES   = 1850;
    localparam int unsigned MAX_PRINTED    = 50;

    // ------------------------------------------------------------------------
    // Scoreboard: running CRC predictor plus queue of awaited reports
    // ------------------------------------------------------------------------
    class crc_check_board;
        logic [15:0] running_crc;
        logic [15:0] expected_crc;
        bit          augment_on;
        bit          erased_skip_on;
        out_item_t   awaited_reports[$];
        int unsigned errors;
        int unsigned reports_checked;
        int unsigned status_count[3];

        function new();
            running_crc    = 16'h0000;
            expected_crc   = 16'h0000;
            augment_on     = 1'b1;
            erased_skip_on = 1'b0;
            errors         = 0;
            reports_checked = 0;
            foreach (status_count[i])
                status_count[i] = 0;
        endfunction

        // One byte into the CRC, MSB first; the bit leaving bit 15 folds in the poly
        function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] data);
            logic [15:0] c;
            logic [7:0]  d;
            c = crc;
            d = data;
            repeat (8)
            begin
                if (c[15])
                    c = {c[14:0], d[7]} ^ CRC_POLY;
                else
                    c = {c[14:0], d[7]};
                d = {d[6:0], 1'b0};
            end
            return c;
        endfunction

        // Final CRC of a region closed by its last byte, from the current state
        function logic [15:0] predict_region(byte_q_t bytes, bit aug);
            logic [15:0] c;
            c = running_crc;
            foreach (bytes[i])
                c = crc_step(c, bytes[i]);
            if (aug)
                c = crc_step(crc_step(c, 8'h00), 8'h00);
            return c;
        endfunction

        function void note_config(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_EXPECTED_CRC: expected_crc   = value[15:0];
                REG_AUGMENT_MODE: augment_on     = value[0];
                REG_ERASED_SKIP:  erased_skip_on = value[0];
                default: ;
            endcase
        endfunction

        // Accepted input transaction
        function void note_byte(in_item_t item);
            logic [15:0] c;
            out_item_t   rep;
            c = crc_step(running_crc, item.data_byte);
            if (!item.last_byte)
            begin
                running_crc = c;
                return;
            end
            if (augment_on)
                c = crc_step(crc_step(c, 8'h00), 8'h00);
            if (erased_skip_on && expected_crc == ERASED_MARK)
                rep.check_status = STATUS_SKIPPED;
            else if (c != expected_crc)
                rep.check_status = STATUS_MISMATCH;
            else
                rep.check_status = STATUS_PASS;
            rep.crc_value = c;
            awaited_reports.push_back(rep);
            running_crc = 16'h0000;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("[%0t] ERROR: %s", $realtime, msg);
        endtask

        // Accepted output transaction
        task check_result(out_item_t got);
            out_item_t want;
            if (awaited_reports.size() == 0)
            begin
                report_mismatch($sformatf("report with none pending: status=%0d crc=%04h",
                                          got.check_status, got.crc_value));
                return;
            end
            want = awaited_reports.pop_front();
            reports_checked++;
            status_count[int'(want.check_status)]++;
            if (got.check_status !== want.check_status)
                report_mismatch($sformatf("check_status %0d, expected %s",
                                          got.check_status, want.check_status.name()));
            if (got.crc_value !== want.crc_value)
                report_mismatch($sformatf("crc_value %04h, expected %04h",
                                          got.crc_value, want.crc_value));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    in_item_t            in_item;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_item_t           out_item;

    crc_check_board sb = new();

    int unsigned bytes_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned phase_count = 0;
    bit          sender_bursty = 1'b1;
    byte_q_t     region_bytes;

    region_crc16_check_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stall pattern: rotating 32-bit mask, reloaded with all ones or a random word
    int unsigned rx_count   = 0;
    logic [31:0] rx_pattern = '1;

    always @(posedge clk)
    begin
        if (rx_count % 64 == 0)
            rx_pattern = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
        rx_pattern = {rx_pattern[30:0], rx_pattern[31]};
        rx_count++;
        out_ready <= rx_pattern[0];
    end

    // Transaction monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(in_item);
            if (out_valid && out_ready)
                sb.check_result(out_item);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One input transaction; opens a new burst with a random gap when needed
    task automatic push_byte(input in_item_t item);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = sender_bursty ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Send a byte sequence; close marks the final byte as the region's last
    task automatic send_region(input byte_q_t bytes, input bit close);
        in_item_t item;
        foreach (bytes[i])
        begin
            item.data_byte = bytes[i];
            item.last_byte = close && (i == bytes.size() - 1);
            push_byte(item);
        end
    endtask

    // Hold input off until every awaited report is back and the pipe settles
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup then access; leaves psel high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.note_config(idx, value);
    endtask

    // New register setting; junk in the upper bits must be dropped
    task automatic apply_config(input logic [15:0] exp_crc, input bit aug, input bit skip);
        wait_idle();
        write_reg(REG_EXPECTED_CRC, {16'($urandom), exp_crc});
        write_reg(REG_AUGMENT_MODE, {31'($urandom), aug});
        write_reg(REG_UNUSED_IDX, 32'($urandom));
        write_reg(REG_ERASED_SKIP, {31'($urandom), skip});
        psel    <= 1'b0;
        penable <= 1'b0;
        phase_count++;
    endtask

    // Random region; terminated regions end with their own augmented CRC,
    // which brings the final CRC to zero in either mode
    task automatic make_region(input bit terminate);
        int unsigned len;
        logic [15:0] c;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        region_bytes.delete();
        repeat (len) region_bytes.push_back(8'($urandom));
        if (terminate && len >= 2)
        begin
            c = 16'h0000;
            for (int i = 0; i < int'(len) - 2; i++)
                c = sb.crc_step(c, region_bytes[i]);
            c = sb.crc_step(sb.crc_step(c, 8'h00), 8'h00);
            region_bytes[len-2] = c[15:8];
            region_bytes[len-1] = c[7:0];
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic run_directed();
        // Reset defaults: expected 0, augmented, no erased skip
        send_region({8'h00}, 1'b1);
        send_region({8'hFF}, 1'b1);
        send_region({8'h80, 8'h01, 8'h7F, 8'hFE}, 1'b1);
        // Erased store: status skipped, CRC still reported
        apply_config(ERASED_MARK, 1'b1, 1'b1);
        send_region({8'hA5}, 1'b1);
        // Erased skip off: 0xFFFF compared normally (FF FF unaugmented gives FFFF)
        apply_config(ERASED_MARK, 1'b0, 1'b0);
        send_region({8'hFF, 8'hFF}, 1'b1);
        // Calibration mode pass with skip on and a non-erased value
        apply_config(16'h1234, 1'b0, 1'b1);
        send_region({8'h12, 8'h34}, 1'b1);
        // Settings changed mid-region take effect at the last byte
        send_region({8'h55, 8'hAA}, 1'b0);
        apply_config(16'h0000, 1'b1, 1'b0);
        send_region({8'hC3}, 1'b1);
        apply_config(ERASED_MARK, 1'b1, 1'b0);
        send_region({8'h00, 8'hFF, 8'h80, 8'h7F}, 1'b1);
    endtask

    task automatic run_random_phase();
        int unsigned n_regions;
        int unsigned sel;
        logic [15:0] exp_crc;
        bit          aug;
        bit          skip;
        n_regions = $urandom_range(3, 30);
        aug  = 1'($urandom_range(0, 1));
        skip = ($urandom_range(0, 2) == 0);
        make_region(1'($urandom_range(0, 1)));
        sel = $urandom_range(0, 7);
        if (sel < 4)
            exp_crc = 16'h0000;
        else if (sel == 4)
            exp_crc = ERASED_MARK;
        else if (sel == 5)
            exp_crc = sb.predict_region(region_bytes, aug);
        else
            exp_crc = 16'($urandom);
        apply_config(exp_crc, aug, skip);
        sender_bursty = ($urandom_range(0, 3) != 0);
        send_region(region_bytes, 1'b1);
        repeat (n_regions - 1)
        begin
            make_region($urandom_range(0, 2) != 0);
            send_region(region_bytes, 1'b1);
        end
        // Sometimes leave a region open across the next register update
        if ($urandom_range(0, 3) == 0)
        begin
            make_region(1'b0);
            send_region(region_bytes, 1'b0);
        end
    endtask

    initial
    begin
        int unsigned random_goal;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b1;
        paddr    = '0;
        pwdata   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        random_goal = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_goal)
            run_random_phase();
        wait_idle();

        $display("Covered %0d bytes in %0d register phases, %0d region reports checked",
                 bytes_sent, phase_count, sb.reports_checked);
        $display("Reports by status: pass %0d, mismatch %0d, skipped %0d",
                 sb.status_count[0], sb.status_count[1], sb.status_count[2]);
        if (sb.errors == 0 && sb.awaited_reports.size() == 0)
            $display("region_crc16_check_unit test passed");
        else
            $display("region_crc16_check_unit test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #8ms;
        $display("region_crc16_check_unit test failed");
        $finish;
    end

endmodule
